/* sv/bst_pkg.sv */
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types and constants of the bounded set table: capacity, field
// widths, operation codes and the command and result records.
// ----------------------------------------------------------------------------
package bst_pkg;

  // Storage geometry
  localparam int CAPACITY        = 32;
  localparam int ELEMENT_WIDTH   = 16;

  // Fixed field widths of the stream items
  localparam int OP_W            = 2;
  localparam int ELEMENT_FIELD_W = 16;
  localparam int COUNT_W         = 6;

  // Bits actually held per entry
  localparam int STORE_W = (ELEMENT_WIDTH < ELEMENT_FIELD_W) ? ELEMENT_WIDTH : ELEMENT_FIELD_W;
  // Entry index and occupancy counter widths
  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);

  // Stream widths
  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 8;
  localparam int M_TDATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY  = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                        operation;
    logic [ELEMENT_FIELD_W-1:0] element;
  } bst_cmd_t;

  typedef struct packed {
    logic               present;
    logic               status;
    logic [COUNT_W-1:0] count;
  } bst_result_t;

endpackage

/* sv/bst_core.sv */
// ----------------------------------------------------------------------------
// bst_core
// Entry memory and sequencer: scans the packed entries one read per cycle,
// appends on insert, and moves later entries down one slot on remove.
// ----------------------------------------------------------------------------
module bst_core import bst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  bst_cmd_t    cmd_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output bst_result_t res_o
);

  // Entry memory, one write and one registered read port
  logic [STORE_W-1:0] mem_q [CAPACITY];
  logic [STORE_W-1:0] rd_data_q;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [STORE_W-1:0] wr_data;

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [STORE_W-1:0] elem_q, elem_d;
  logic [CNT_W-1:0]   occ_q, occ_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic               chk_q, chk_d;
  logic [IDX_W-1:0]   chk_idx_q, chk_idx_d;
  logic               present_q, present_d;
  logic               status_q, status_d;
  logic               hit;

  // Write and read the entry memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      occ_q     <= '0;
      chk_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      chk_q     <= chk_d;
    end
  end

  // Hold item payload and scan position
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    elem_q    <= elem_d;
    ptr_q     <= ptr_d;
    chk_idx_q <= chk_idx_d;
    present_q <= present_d;
    status_q  <= status_d;
  end

  // Match on the entry read in the previous cycle
  assign hit = chk_q && (rd_data_q == elem_q);

  // Sequence scan, append and shift
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    elem_d      = elem_q;
    occ_d       = occ_q;
    ptr_d       = ptr_q;
    chk_d       = 1'b0;
    chk_idx_d   = chk_idx_q;
    present_d   = present_q;
    status_d    = status_q;
    rd_en       = 1'b0;
    rd_addr     = ptr_q[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = occ_q[IDX_W-1:0];
    wr_data     = elem_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_d    = cmd_i.operation;
          elem_d  = cmd_i.element[STORE_W-1:0];
          ptr_d   = '0;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (hit || (ptr_q == occ_q)) begin
          // Scan settled: act on the outcome
          present_d = hit;
          status_d  = 1'b0;
          state_d   = ST_DONE;
          case (op_q)
            OP_INSERT: begin
              if (!hit) begin
                if (occ_q < CNT_W'(CAPACITY)) begin
                  wr_en = 1'b1;
                  occ_d = occ_q + CNT_W'(1);
                end else begin
                  status_d = 1'b1;
                end
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                ptr_d   = CNT_W'(chk_idx_q) + CNT_W'(1);
                state_d = ST_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end else begin
          // Issue the next entry read
          rd_en     = 1'b1;
          chk_d     = 1'b1;
          chk_idx_d = ptr_q[IDX_W-1:0];
          ptr_d     = ptr_q + CNT_W'(1);
        end
      end

      ST_SHIFT: begin
        // Move the entry read last cycle down one slot
        if (chk_q) begin
          wr_en   = 1'b1;
          wr_addr = chk_idx_q - IDX_W'(1);
          wr_data = rd_data_q;
        end
        if (ptr_q != occ_q) begin
          rd_en     = 1'b1;
          chk_d     = 1'b1;
          chk_idx_d = ptr_q[IDX_W-1:0];
          ptr_d     = ptr_q + CNT_W'(1);
        end else begin
          occ_d   = occ_q - CNT_W'(1);
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.present = present_q;
  assign res_o.status  = status_q;
  assign res_o.count   = COUNT_W'(occ_q);

endmodule

/* sv/bounded_set_table.sv */
// ----------------------------------------------------------------------------
// bounded_set_table
// Set of distinct values in a packed table with a count; query, insert and
// remove one element per item, one result item per input item.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                                  | tuser
//  s_axis  | in        | [15:0] element                         | [1:0] operation
//  m_axis  | out       | [0] present, [1] status, [7:2] count   | -
//
//  One item at a time: the block takes it, scans through the single read port
//  of the entry memory and then hands the result over. An absent value scans
//  every held entry; a held value ends the scan at its slot. A remove that
//  hits then moves each later entry down one slot before it finishes.
//  Reset clears the count; the entry memory is not cleared. A stalled result
//  sits in the output register while the next item is taken and scanned.
module bounded_set_table import bst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [15:0] element
  input  logic [S_TUSER_W-1:0] s_axis_tuser,  // [1:0] operation, rest zero
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata   // [0] present, [1] status, [7:2] count
);

  bst_cmd_t    cmd;
  bst_result_t res;
  logic        res_valid;
  logic        res_ready;
  logic        out_valid_q, out_valid_d;
  bst_result_t out_q;

  assign cmd.operation = op_e'(s_axis_tuser[OP_W-1:0]);
  assign cmd.element   = s_axis_tdata[ELEMENT_FIELD_W-1:0];

  bst_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Take a result when the output register is empty or draining
  assign res_ready   = !out_valid_q || m_axis_tready;
  assign out_valid_d = res_valid ? 1'b1 : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.count, out_q.status, out_q.present};

endmodule

/* sv/bst_checker.sv */
// ----------------------------------------------------------------------------
// bst_checker
// Port-level checks of the bounded set table, bound to the top level.
// ----------------------------------------------------------------------------
module bst_checker import bst_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic [S_TUSER_W-1:0] s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Take one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while another is in work");

  // Count stays within capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:2] <= CAPACITY)
    else $error("count above capacity");

  // Overflow only on a full set with the value absent
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0] && (m_axis_tdata[7:2] == CAPACITY))
    else $error("overflow reported on a set that is not full");

endmodule

bind bounded_set_table bst_checker u_bst_checker (.*);

/* dv/tb_bounded_set_table.sv */
// ----------------------------------------------------------------------------
// tb_bounded_set_table
// Self-checking bench for the bounded set table. A membership tracker keeps
// its own copy of the held values, predicts present, status and count for
// every accepted command item and checks result items in order. Stimulus
// runs a short directed sequence, then fill, drain, mixed and noise rounds
// with random idling on both sides, one long output hold-off and one drain
// pause.
// ----------------------------------------------------------------------------
module tb_bounded_set_table;
  import bst_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 600;
  localparam int QUIET_ITEMS  = 100;
  localparam int POOL_SIZE    = 48;

  // Operation code that the package leaves unnamed; the block treats it as a query
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Kinds of random rounds
  localparam int ROUND_FILL  = 0;
  localparam int ROUND_DRAIN = 1;
  localparam int ROUND_MIXED = 2;
  localparam int ROUND_NOISE = 3;

  // Tracks the held values and the results still owed by the block
  class membership_tracker;
    logic [STORE_W-1:0] held_values[$];
    bst_result_t        owed_results[$];
    int unsigned        mismatches;
    int unsigned        results_seen;

    function int pending();
      return owed_results.size();
    endfunction

    // Update the held values for one accepted command and queue its result
    function void predict_op(logic [OP_W-1:0] op_bits, logic [ELEMENT_FIELD_W-1:0] element);
      logic [STORE_W-1:0] key;
      int                 slot;
      bst_result_t        res;
      key  = element[STORE_W-1:0];
      slot = -1;
      foreach (held_values[i]) begin
        if (slot < 0 && held_values[i] == key) slot = i;
      end
      res.present = (slot >= 0);
      res.status  = 1'b0;
      case (op_bits)
        OP_INSERT: begin
          if (slot < 0) begin
            if (held_values.size() < CAPACITY) held_values.push_back(key);
            else res.status = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (slot >= 0) held_values.delete(slot);
        end
        default: ;
      endcase
      res.count = COUNT_W'(held_values.size());
      owed_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    // Compare one result item against the oldest owed result
    task check_result(logic [M_TDATA_W-1:0] tdata);
      bst_result_t want;
      results_seen++;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result %0d (0x%02h) arrived with none owed",
                                  results_seen, tdata));
        return;
      end
      want = owed_results.pop_front();
      if (tdata[0] !== want.present)
        report_mismatch($sformatf("result %0d present %b, want %b",
                                  results_seen, tdata[0], want.present));
      if (tdata[1] !== want.status)
        report_mismatch($sformatf("result %0d status %b, want %b",
                                  results_seen, tdata[1], want.status));
      if (tdata[7:2] !== want.count)
        report_mismatch($sformatf("result %0d count %0d, want %0d",
                                  results_seen, tdata[7:2], want.count));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // [15:0] element
  logic [S_TUSER_W-1:0] s_axis_tuser;   // [1:0] operation, rest zero
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // [0] present, [1] status, [7:2] count

  membership_tracker tracker = new();

  int unsigned        cycle_count;
  int unsigned        items_sent;
  bit                 quiet;
  bit                 calm_sender;
  bit                 hold_request;
  logic [STORE_W-1:0] value_pool[POOL_SIZE];

  bounded_set_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watch both handshakes; commands are predicted, results checked
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (s_axis_tvalid && s_axis_tready)
        tracker.predict_op(s_axis_tuser[OP_W-1:0], s_axis_tdata[ELEMENT_FIELD_W-1:0]);
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_result(m_axis_tdata);
    end
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_bounded_set_table: FAIL");
    $finish;
  end

  // Result receiver: random stall bursts, one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one command item and hold it until taken
  task automatic send_item(logic [OP_W-1:0] op_bits, logic [ELEMENT_FIELD_W-1:0] element);
    if (!quiet && !calm_sender && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= S_TDATA_W'($urandom);
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(element);
    s_axis_tuser  <= S_TUSER_W'(op_bits);
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // Stop offering and wait until every owed result has come back
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Pick a currently held value half the time, else one from the pool
  function automatic logic [STORE_W-1:0] pick_value();
    if (tracker.held_values.size() != 0 && $urandom_range(0, 1) == 0)
      return tracker.held_values[$urandom_range(0, tracker.held_values.size() - 1)];
    return value_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic run_round(int kind, int n);
    logic [OP_W-1:0]            op_bits;
    logic [ELEMENT_FIELD_W-1:0] element;
    for (int k = 0; k < n; k++) begin
      case (kind)
        ROUND_FILL: begin
          op_bits = ($urandom_range(0, 9) == 0) ? OP_QUERY : OP_INSERT;
          element = ($urandom_range(0, 9) < 7) ? ELEMENT_FIELD_W'($urandom) : pick_value();
        end
        ROUND_DRAIN: begin
          op_bits = ($urandom_range(0, 9) == 0) ? OP_QUERY : OP_REMOVE;
          element = ($urandom_range(0, 7) == 0) ? ELEMENT_FIELD_W'($urandom) : pick_value();
        end
        ROUND_MIXED: begin
          op_bits = OP_W'($urandom_range(0, 3));
          element = pick_value();
        end
        default: begin
          op_bits = OP_W'($urandom);
          element = ELEMENT_FIELD_W'($urandom);
        end
      endcase
      if (items_sent >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_item(op_bits, element);
    end
  endtask

  // Main sequence
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    items_sent    = 0;
    quiet         = 1'b0;
    calm_sender   = 1'b0;
    hold_request  = 1'b0;
    foreach (value_pool[i]) value_pool[i] = STORE_W'($urandom);
    value_pool[0] = '0;
    value_pool[1] = '1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty set, extremes, duplicate insert, unused code,
    // removal from the front and the back, stale slot after removal
    send_item(OP_QUERY,  16'h0000);
    send_item(OP_REMOVE, 16'hFFFF);
    send_item(OP_INSERT, 16'h0000);
    send_item(OP_INSERT, 16'hFFFF);
    send_item(OP_INSERT, 16'h0000);
    send_item(OP_QUERY,  16'h0000);
    send_item(OP_UNUSED, 16'hFFFF);
    send_item(OP_UNUSED, 16'h1234);
    send_item(OP_REMOVE, 16'h0000);
    send_item(OP_QUERY,  16'h0000);
    send_item(OP_REMOVE, 16'h1234);
    send_item(OP_REMOVE, 16'hFFFF);
    send_item(OP_QUERY,  16'hFFFF);
    send_item(OP_INSERT, 16'h5555);
    send_item(OP_INSERT, 16'hAAAA);
    send_item(OP_REMOVE, 16'h5555);
    send_item(OP_QUERY,  16'hAAAA);

    // Fill past capacity with the output held off so the block backs up
    items_sent   = 0;
    hold_request = 1'b1;
    run_round(ROUND_FILL, 45);
    // Mixed queries, inserts, removes and unused codes on held and pool values
    run_round(ROUND_MIXED, 10);
    wait_all_results();

    // Random rounds until the budget is spent
    while (items_sent < RANDOM_ITEMS) begin
      calm_sender = ($urandom_range(0, 3) == 0);
      run_round($urandom_range(ROUND_FILL, ROUND_NOISE), $urandom_range(10, 50));
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));
    if (tracker.mismatches == 0) begin
      $display("tb_bounded_set_table: PASS");
    end else begin
      $display("tb_bounded_set_table: FAIL");
    end
    $finish;
  end

endmodule
